// ===== src/tcp_nat_mapping_engine_top_assert.svh =====
// ----------------------------------------------------------------------------
// tcp_nat_mapping_engine_top_assert.svh
// Assertion macros used by the checker of the NAT mapping engine.
// They expect signals named clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef TCP_NAT_MAPPING_ENGINE_TOP_ASSERT_SVH
`define TCP_NAT_MAPPING_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NME_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("NAT engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define NME_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("NAT engine check failed");

`endif

// ===== src/nme_pkg.sv =====
// ----------------------------------------------------------------------------
// nme_pkg
// Types, codes and defaults shared by the NAT mapping engine modules.
// ----------------------------------------------------------------------------
package nme_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int PORT_BASE_DEF     = 12345;
	localparam int PORT_COUNT_DEF    = 1024;

	localparam int IN_DATA_W  = 168;
	localparam int OUT_DATA_W = 104;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam int FLAG_FIN = 0;
	localparam int FLAG_SYN = 1;
	localparam int FLAG_RST = 2;
	localparam int FLAG_ACK = 4;

	localparam logic [15:0] IDLE_LIMIT_RESET = 16'd60;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PUBLIC_ADDRESS,
		REG_RULE_COUNT,
		REG_RULE_A_PUBLIC,
		REG_RULE_A_PRIVATE,
		REG_RULE_B_PUBLIC,
		REG_RULE_B_PRIVATE,
		REG_IDLE_LIMIT
	} reg_idx_t;

	typedef enum logic [1:0] {
		VERD_FORWARD = 2'd0,
		VERD_NO_MAP  = 2'd1,
		VERD_NO_RES  = 2'd2,
		VERD_TICK    = 2'd3
	} verdict_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LK_RD,
		ST_LK_CMP,
		ST_CREATE,
		ST_PL_RD,
		ST_PL_CMP,
		ST_SW_RD,
		ST_SW_CMP,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [31:0] public_address;
		logic [1:0]  rule_count;
		logic [47:0] rule_a_public;
		logic [47:0] rule_a_private;
		logic [47:0] rule_b_public;
		logic [47:0] rule_b_private;
		logic [15:0] idle_limit;
	} cfg_t;

	typedef struct packed {
		logic        cmd;
		logic        inbound;
		logic [31:0] src_addr;
		logic [15:0] src_port;
		logic [31:0] dst_addr;
		logic [15:0] dst_port;
		logic [7:0]  tcp_flags;
		logic [31:0] seq_end;
		logic [31:0] ack_number;
	} req_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] out_src_addr;
		logic [15:0] out_src_port;
		logic [31:0] out_dst_addr;
		logic [15:0] out_dst_port;
		logic [6:0]  removed_count;
	} res_t;

	typedef struct packed {
		logic [31:0] peer_addr;
		logic [15:0] peer_port;
		logic [31:0] mapped_addr;
		logic [15:0] mapped_port;
		logic [31:0] inner_addr;
		logic [15:0] inner_port;
		logic        inner_fin;
		logic        outer_fin;
		logic [31:0] inner_seq;
		logic [31:0] outer_seq;
		logic [31:0] inner_ack;
		logic [31:0] outer_ack;
		logic [31:0] last_seen;
	} row_t;

endpackage

// ===== src/nme_ram.sv =====
// ----------------------------------------------------------------------------
// nme_ram
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nme_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/nme_ctrl.sv =====
// ----------------------------------------------------------------------------
// nme_ctrl
// Sequencer that walks the mapping table and the port pool one entry at a
// time through a shared compare unit, and holds the result register.
// ----------------------------------------------------------------------------
module nme_ctrl #(
	parameter int TABLE_ENTRIES = nme_pkg::TABLE_ENTRIES_DEF,
	parameter int PORT_BASE     = nme_pkg::PORT_BASE_DEF,
	parameter int PORT_COUNT    = nme_pkg::PORT_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  nme_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  nme_pkg::req_t in_req,
	output logic          out_valid,
	input  logic          out_ready,
	output nme_pkg::res_t out_res
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int RW = $bits(nme_pkg::row_t);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
	localparam logic [PW-1:0] LAST_PJ  = PW'(PORT_COUNT - 1);
	localparam logic [16:0]   BASE17   = 17'(PORT_BASE);

	nme_pkg::state_t state_q, state_d;
	nme_pkg::req_t   req_q;
	nme_pkg::res_t   res_q, res_d, out_q;
	logic [IW-1:0]   idx_q, free_idx_q;
	logic            free_found_q;
	logic [PW-1:0]   pj_q;
	logic [TABLE_ENTRIES-1:0] valid_q, owns_q;
	logic [31:0]     now_q;
	logic [6:0]      removed_q, removed_next;
	logic            out_valid_q;

	// Memory ports
	nme_pkg::row_t   row_rd, row_wdata;
	logic [RW-1:0]   row_rdata;
	logic            row_we;
	logic [IW-1:0]   row_waddr;
	logic            pool_rdata, pool_we, pool_wdata;
	logic [PW-1:0]   pool_waddr;

	// Control from the output block
	logic            accept, res_load, free_note, idx_inc, pj_inc, pj_clr;
	logic            set_en, set_owns, clr_en;
	logic [IW-1:0]   set_addr;

	// Compare unit
	logic [31:0] ra;
	logic [15:0] rp;
	logic        hit, last_idx, last_pj;
	logic        rule_a_en, rule_b_en, a_match, b_match;
	logic [47:0] rule_prv;
	logic [16:0] port17, pool_diff;
	logic        port_ok, reserved, pool_free;
	logic        aged, done, drop;
	logic        f_fin, f_syn, f_rst, f_ack;

	nme_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(RW), .AW(IW)) u_rows (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.raddr (idx_q),
		.rdata (row_rdata)
	);

	nme_ram #(.DEPTH(PORT_COUNT), .WIDTH(1), .AW(PW)) u_pool (
		.clk   (clk),
		.we    (pool_we),
		.waddr (pool_waddr),
		.wdata (pool_wdata),
		.raddr (pj_q),
		.rdata (pool_rdata)
	);

	assign row_rd = nme_pkg::row_t'(row_rdata);

	assign f_fin = req_q.tcp_flags[nme_pkg::FLAG_FIN];
	assign f_syn = req_q.tcp_flags[nme_pkg::FLAG_SYN];
	assign f_rst = req_q.tcp_flags[nme_pkg::FLAG_RST];
	assign f_ack = req_q.tcp_flags[nme_pkg::FLAG_ACK];

	assign ra = req_q.inbound ? req_q.src_addr : req_q.dst_addr;
	assign rp = req_q.inbound ? req_q.src_port : req_q.dst_port;

	always_comb begin
		logic peer_hit, side_hit;
		peer_hit = valid_q[idx_q] && row_rd.peer_addr == ra && row_rd.peer_port == rp;
		if (req_q.inbound) begin
			side_hit = row_rd.mapped_addr == req_q.dst_addr &&
				row_rd.mapped_port == req_q.dst_port;
		end else begin
			side_hit = row_rd.inner_addr == req_q.src_addr &&
				row_rd.inner_port == req_q.src_port;
		end
		hit = peer_hit && side_hit;
	end

	assign last_idx = idx_q == LAST_IDX;
	assign last_pj  = pj_q == LAST_PJ;

	// A rule count of three behaves as two.
	assign rule_a_en = cfg.rule_count != 2'd0;
	assign rule_b_en = cfg.rule_count[1];
	assign a_match = rule_a_en && cfg.rule_a_public[47:16] == req_q.dst_addr &&
		cfg.rule_a_public[15:0] == req_q.dst_port;
	assign b_match = rule_b_en && cfg.rule_b_public[47:16] == req_q.dst_addr &&
		cfg.rule_b_public[15:0] == req_q.dst_port;
	assign rule_prv = a_match ? cfg.rule_a_private : cfg.rule_b_private;

	assign port17    = BASE17 + 17'(pj_q);
	assign port_ok   = port17 <= 17'h0FFFF;
	assign reserved  = (rule_a_en && cfg.rule_a_public[15:0] == port17[15:0]) ||
		(rule_b_en && cfg.rule_b_public[15:0] == port17[15:0]);
	assign pool_free = !pool_rdata && !reserved;
	assign pool_diff = {1'b0, row_rd.mapped_port} - BASE17;

	assign aged = (now_q - row_rd.last_seen) > {16'd0, cfg.idle_limit};
	assign done = row_rd.inner_fin && row_rd.outer_fin &&
		row_rd.inner_ack >= row_rd.outer_seq && row_rd.outer_ack >= row_rd.inner_seq;
	assign drop = valid_q[idx_q] && (aged || done);
	assign removed_next = (drop && removed_q != 7'd127) ? removed_q + 7'd1 : removed_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nme_pkg::ST_CLEAR: begin
				if (last_pj) begin
					state_d = nme_pkg::ST_IDLE;
				end
			end
			nme_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = in_req.cmd ? nme_pkg::ST_SW_RD : nme_pkg::ST_LK_RD;
				end
			end
			nme_pkg::ST_LK_RD: state_d = nme_pkg::ST_LK_CMP;
			nme_pkg::ST_LK_CMP: begin
				priority if (hit) begin
					state_d = nme_pkg::ST_RESP;
				end else if (last_idx) begin
					state_d = nme_pkg::ST_CREATE;
				end else begin
					state_d = nme_pkg::ST_LK_RD;
				end
			end
			nme_pkg::ST_CREATE: begin
				if (f_syn && !req_q.inbound && free_found_q) begin
					state_d = nme_pkg::ST_PL_RD;
				end else begin
					state_d = nme_pkg::ST_RESP;
				end
			end
			nme_pkg::ST_PL_RD: state_d = nme_pkg::ST_PL_CMP;
			nme_pkg::ST_PL_CMP: begin
				if (!port_ok || pool_free || last_pj) begin
					state_d = nme_pkg::ST_RESP;
				end else begin
					state_d = nme_pkg::ST_PL_RD;
				end
			end
			nme_pkg::ST_SW_RD: state_d = nme_pkg::ST_SW_CMP;
			nme_pkg::ST_SW_CMP: begin
				state_d = last_idx ? nme_pkg::ST_RESP : nme_pkg::ST_SW_RD;
			end
			nme_pkg::ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					state_d = nme_pkg::ST_IDLE;
				end
			end
			default: state_d = nme_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_ready   = 1'b0;
		accept     = 1'b0;
		res_load   = 1'b0;
		free_note  = 1'b0;
		idx_inc    = 1'b0;
		pj_inc     = 1'b0;
		pj_clr     = 1'b0;
		set_en     = 1'b0;
		set_owns   = 1'b0;
		set_addr   = free_idx_q;
		clr_en     = 1'b0;
		row_we     = 1'b0;
		row_waddr  = idx_q;
		row_wdata  = row_rd;
		pool_we    = 1'b0;
		pool_waddr = pj_q;
		pool_wdata = 1'b0;

		res_d = '{verdict: nme_pkg::VERD_FORWARD,
			out_src_addr: req_q.src_addr, out_src_port: req_q.src_port,
			out_dst_addr: req_q.dst_addr, out_dst_port: req_q.dst_port,
			removed_count: 7'd0};

		unique case (state_q)
			nme_pkg::ST_CLEAR: begin
				pool_we = 1'b1;
				pj_inc  = 1'b1;
			end
			nme_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
			end
			nme_pkg::ST_LK_CMP: begin
				free_note = !valid_q[idx_q] && !free_found_q;
				if (hit) begin
					res_load = 1'b1;
					row_we   = 1'b1;
					row_wdata.last_seen = now_q;
					if (req_q.inbound) begin
						res_d.out_dst_addr  = row_rd.inner_addr;
						res_d.out_dst_port  = row_rd.inner_port;
						row_wdata.outer_fin = f_fin;
						row_wdata.outer_seq = req_q.seq_end;
						if (f_ack) begin
							row_wdata.outer_ack = req_q.ack_number;
						end
					end else begin
						res_d.out_src_addr  = row_rd.mapped_addr;
						res_d.out_src_port  = row_rd.mapped_port;
						row_wdata.inner_fin = f_fin;
						row_wdata.inner_seq = req_q.seq_end;
						if (f_ack) begin
							row_wdata.inner_ack = req_q.ack_number;
						end
					end
					// A reset segment is forwarded and then tears the flow down.
					if (f_rst) begin
						clr_en     = 1'b1;
						pool_we    = owns_q[idx_q];
						pool_waddr = pool_diff[PW-1:0];
					end
				end else begin
					idx_inc = !last_idx;
				end
			end
			nme_pkg::ST_CREATE: begin
				row_waddr = free_idx_q;
				row_wdata = '{peer_addr: ra, peer_port: rp,
					mapped_addr: req_q.dst_addr, mapped_port: req_q.dst_port,
					inner_addr: rule_prv[47:16], inner_port: rule_prv[15:0],
					inner_fin: 1'b0, outer_fin: f_fin, inner_seq: 32'd0,
					outer_seq: req_q.seq_end, inner_ack: 32'd0,
					outer_ack: f_ack ? req_q.ack_number : 32'd0, last_seen: now_q};
				pj_clr = 1'b1;
				priority if (!f_syn) begin
					res_load      = 1'b1;
					res_d.verdict = nme_pkg::VERD_NO_MAP;
				end else if (req_q.inbound) begin
					res_load = 1'b1;
					if ((a_match || b_match) && free_found_q) begin
						row_we             = 1'b1;
						set_en             = 1'b1;
						res_d.out_dst_addr = rule_prv[47:16];
						res_d.out_dst_port = rule_prv[15:0];
					end else begin
						res_d.verdict = nme_pkg::VERD_NO_RES;
					end
				end else if (!free_found_q) begin
					res_load      = 1'b1;
					res_d.verdict = nme_pkg::VERD_NO_RES;
				end else begin
					res_load = 1'b0;
				end
			end
			nme_pkg::ST_PL_CMP: begin
				row_waddr = free_idx_q;
				row_wdata = '{peer_addr: ra, peer_port: rp,
					mapped_addr: cfg.public_address, mapped_port: port17[15:0],
					inner_addr: req_q.src_addr, inner_port: req_q.src_port,
					inner_fin: f_fin, outer_fin: 1'b0, inner_seq: req_q.seq_end,
					outer_seq: 32'd0, inner_ack: f_ack ? req_q.ack_number : 32'd0,
					outer_ack: 32'd0, last_seen: now_q};
				priority if (!port_ok) begin
					res_load      = 1'b1;
					res_d.verdict = nme_pkg::VERD_NO_RES;
				end else if (pool_free) begin
					res_load           = 1'b1;
					row_we             = 1'b1;
					set_en             = 1'b1;
					set_owns           = 1'b1;
					pool_we            = 1'b1;
					pool_wdata         = 1'b1;
					res_d.out_src_addr = cfg.public_address;
					res_d.out_src_port = port17[15:0];
				end else if (last_pj) begin
					res_load      = 1'b1;
					res_d.verdict = nme_pkg::VERD_NO_RES;
				end else begin
					pj_inc = 1'b1;
				end
			end
			nme_pkg::ST_SW_CMP: begin
				idx_inc = !last_idx;
				if (drop) begin
					clr_en     = 1'b1;
					pool_we    = owns_q[idx_q];
					pool_waddr = pool_diff[PW-1:0];
				end
				if (last_idx) begin
					res_load = 1'b1;
					res_d = '{verdict: nme_pkg::VERD_TICK, out_src_addr: 32'd0,
						out_src_port: 16'd0, out_dst_addr: 32'd0,
						out_dst_port: 16'd0, removed_count: removed_next};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= nme_pkg::ST_CLEAR;
			idx_q        <= '0;
			free_found_q <= 1'b0;
			pj_q         <= '0;
			valid_q      <= '0;
			owns_q       <= '0;
			now_q        <= 32'd0;
			removed_q    <= 7'd0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q        <= '0;
				free_found_q <= 1'b0;
				removed_q    <= 7'd0;
				if (in_req.cmd) begin
					now_q <= now_q + 32'd1;
				end
			end
			if (free_note) begin
				free_found_q <= 1'b1;
			end
			if (idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (pj_clr) begin
				pj_q <= '0;
			end else if (pj_inc) begin
				pj_q <= pj_q + PW'(1);
			end
			if (state_q == nme_pkg::ST_SW_CMP) begin
				removed_q <= removed_next;
			end
			if (set_en) begin
				valid_q[set_addr] <= 1'b1;
				owns_q[set_addr]  <= set_owns;
			end
			if (clr_en) begin
				valid_q[idx_q] <= 1'b0;
				owns_q[idx_q]  <= 1'b0;
			end
			if (state_q == nme_pkg::ST_RESP && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_req;
		end
		if (free_note) begin
			free_idx_q <= idx_q;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (state_q == nme_pkg::ST_RESP && (!out_valid_q || out_ready)) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// ===== src/tcp_nat_mapping_engine_top.sv =====
// ----------------------------------------------------------------------------
// tcp_nat_mapping_engine_top
// TCP port and address translation table with an aging sweep on each tick.
//
// Channel   Dir  Handshake          Contents
// s_*       in   tvalid/tready      segment request or tick
// m_*       out  tvalid/tready      verdict and translated header
// cfg_*     in   cfg_we             register writes, no read-back
//
// A request is accepted in the idle state. A segment then reads and compares
// table entries one at a time up to the first match; a miss scans every entry
// and then decides in the create state, and an outbound SYN with a free table
// slot then reads and compares pool ports one at a time. A tick reads and
// compares every table entry. The result is then moved to the output register,
// and it waits while that register still holds an unaccepted result. After
// reset a clearing pass goes over the port pool.
// ----------------------------------------------------------------------------
module tcp_nat_mapping_engine_top #(
	parameter int TABLE_ENTRIES = nme_pkg::TABLE_ENTRIES_DEF,
	parameter int PORT_BASE     = nme_pkg::PORT_BASE_DEF,
	parameter int PORT_COUNT    = nme_pkg::PORT_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// src_addr, src_port, dst_addr, dst_port, tcp_flags, seq_end, ack_number
	input  logic [nme_pkg::IN_DATA_W-1:0]  s_tdata,
	// cmd, inbound
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_src_addr, out_src_port, out_dst_addr, out_dst_port, removed_count, pad
	output logic [nme_pkg::OUT_DATA_W-1:0] m_tdata,
	// verdict
	output logic [1:0]                     m_tuser,
	input  logic                           cfg_we,
	input  logic [nme_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nme_pkg::CFG_DATA_W-1:0] cfg_data
);

	nme_pkg::cfg_t cfg_q;
	nme_pkg::req_t req;
	nme_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{public_address: 32'd0, rule_count: 2'd0,
				rule_a_public: 48'd0, rule_a_private: 48'd0,
				rule_b_public: 48'd0, rule_b_private: 48'd0,
				idle_limit: nme_pkg::IDLE_LIMIT_RESET};
		end else if (cfg_we) begin
			unique case (cfg_index)
				nme_pkg::REG_PUBLIC_ADDRESS: cfg_q.public_address <= cfg_data[31:0];
				nme_pkg::REG_RULE_COUNT:     cfg_q.rule_count     <= cfg_data[1:0];
				nme_pkg::REG_RULE_A_PUBLIC:  cfg_q.rule_a_public  <= cfg_data;
				nme_pkg::REG_RULE_A_PRIVATE: cfg_q.rule_a_private <= cfg_data;
				nme_pkg::REG_RULE_B_PUBLIC:  cfg_q.rule_b_public  <= cfg_data;
				nme_pkg::REG_RULE_B_PRIVATE: cfg_q.rule_b_private <= cfg_data;
				nme_pkg::REG_IDLE_LIMIT:     cfg_q.idle_limit     <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign req = '{cmd: s_tuser[0], inbound: s_tuser[1],
		src_addr: s_tdata[31:0], src_port: s_tdata[47:32],
		dst_addr: s_tdata[79:48], dst_port: s_tdata[95:80],
		tcp_flags: s_tdata[103:96], seq_end: s_tdata[135:104],
		ack_number: s_tdata[167:136]};

	nme_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.PORT_BASE     (PORT_BASE),
		.PORT_COUNT    (PORT_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (req),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tuser = res.verdict;
	assign m_tdata = {1'b0, res.removed_count, res.out_dst_port, res.out_dst_addr,
		res.out_src_port, res.out_src_addr};

endmodule

// ===== src/nme_checker.sv =====
// ----------------------------------------------------------------------------
// nme_checker
// Port-level checks for the NAT mapping engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "tcp_nat_mapping_engine_top_assert.svh"

module nme_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [nme_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]                     m_tuser
);

	`NME_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`NME_ASSERT_SAME(a_tick_zero, m_tvalid && m_tuser == nme_pkg::VERD_TICK, m_tdata[95:0] == 96'd0)
	`NME_ASSERT_SAME(a_xlate_count, m_tvalid && m_tuser != nme_pkg::VERD_TICK, m_tdata[102:96] == 7'd0)
	`NME_ASSERT_NEXT(a_busy_after, s_tvalid && s_tready, !s_tready)

endmodule

bind tcp_nat_mapping_engine_top nme_checker u_nme_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
